@@ hdl/arp_pkg.sv @@
// shared types, constants and byte helpers for the arp reply block
// no dependencies; imported by arp_check, arp_reply, the top level and the testbench
package arp_pkg;

    // frame header geometry
    localparam int HDR_DEPTH = 42;
    localparam int CNT_W     = 6;
    localparam int MAC_W     = 48;
    localparam int IP_W      = 32;
    localparam int CFG_W     = 48;
    localparam int CFG_IDX_W = 1;

    localparam logic [CNT_W-1:0] HDR_BYTES = 6'd42;
    localparam logic [CNT_W-1:0] LAST_IDX  = 6'd41;

    // protocol constants
    localparam logic [15:0] ETH_TYPE_ARP = 16'h0806;
    localparam logic [15:0] PTYPE_IPV4   = 16'h0800;
    localparam logic [15:0] OP_REQUEST   = 16'h0001;
    localparam logic [15:0] OP_REPLY     = 16'h0002;
    localparam logic [7:0]  BCAST_OCTET  = 8'hff;

    // configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_MAC = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_IP  = 1'd1;
    localparam logic [MAC_W-1:0]     MAC_RESET      = 48'h0001_0001_0001;
    localparam logic [IP_W-1:0]      IP_RESET       = 32'h0a00_0002;

    // control sequencer states
    typedef enum logic [2:0] {
        ST_RECV,
        ST_SCAN,
        ST_SETTLE,
        ST_DECIDE,
        ST_EMIT
    } state_t;

    // tag that travels with a store read to the consumer of its data
    typedef struct packed {
        logic             chk;
        logic             ld;
        logic [CNT_W-1:0] idx;
    } rd_tag_t;

    // octet i of a mac address, first octet most significant
    function automatic logic [7:0] mac_octet(input logic [MAC_W-1:0] mac,
                                             input logic [2:0] i);
        logic [7:0] o;
        case (i)
            3'd0:    o = mac[47:40];
            3'd1:    o = mac[39:32];
            3'd2:    o = mac[31:24];
            3'd3:    o = mac[23:16];
            3'd4:    o = mac[15:8];
            3'd5:    o = mac[7:0];
            default: o = 8'd0;
        endcase
        return o;
    endfunction

    // octet i of an ipv4 address, first octet most significant
    function automatic logic [7:0] ip_octet(input logic [IP_W-1:0] ip,
                                            input logic [1:0] i);
        logic [7:0] o;
        case (i)
            2'd0:    o = ip[31:24];
            2'd1:    o = ip[23:16];
            2'd2:    o = ip[15:8];
            default: o = ip[7:0];
        endcase
        return o;
    endfunction

    // store address that feeds reply byte idx (don't care for generated bytes)
    function automatic logic [CNT_W-1:0] src_addr(input logic [CNT_W-1:0] idx);
        logic [CNT_W-1:0] a;
        case (idx) inside
            [6'd0:6'd5]:   a = idx + 6'd6;
            [6'd12:6'd19]: a = idx;
            [6'd32:6'd41]: a = idx - 6'd10;
            default:       a = '0;
        endcase
        return a;
    endfunction

endpackage

@@ hdl/arp_ram.sv @@
// generic simple dual port ram, one write and one registered read port
// no dependencies
module arp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 42
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/arp_check.sv @@
// request checker: accumulates match flags while the stored header is scanned
// depends on arp_pkg
module arp_check (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    clear,
    input  arp_pkg::rd_tag_t        tag,
    input  logic [7:0]              rd_data,
    input  logic [arp_pkg::MAC_W-1:0] server_mac,
    input  logic [arp_pkg::IP_W-1:0]  server_ip,
    output logic                    pass
);
    import arp_pkg::*;

    logic             dmac_reg, dmac_next;
    logic             bcast_reg, bcast_next;
    logic             fix_reg, fix_next;
    logic             tmac_reg, tmac_next;
    logic             tip_reg, tip_next;
    logic [CNT_W-1:0] tmac_off;
    logic [CNT_W-1:0] tip_off;

    assign tmac_off = tag.idx - 6'd32;
    assign tip_off  = tag.idx - 6'd38;

    // per-byte compare against the expected value for that header position
    always_comb
    begin
        dmac_next  = dmac_reg;
        bcast_next = bcast_reg;
        fix_next   = fix_reg;
        tmac_next  = tmac_reg;
        tip_next   = tip_reg;
        if (clear)
        begin
            dmac_next  = 1'b1;
            bcast_next = 1'b1;
            fix_next   = 1'b1;
            tmac_next  = 1'b1;
            tip_next   = 1'b1;
        end
        else if (tag.chk)
        begin
            case (tag.idx) inside
                [6'd0:6'd5]:
                begin
                    dmac_next  = dmac_reg && (rd_data == mac_octet(server_mac, tag.idx[2:0]));
                    bcast_next = bcast_reg && (rd_data == BCAST_OCTET);
                end
                6'd12:   fix_next = fix_reg && (rd_data == ETH_TYPE_ARP[15:8]);
                6'd13:   fix_next = fix_reg && (rd_data == ETH_TYPE_ARP[7:0]);
                6'd16:   fix_next = fix_reg && (rd_data == PTYPE_IPV4[15:8]);
                6'd17:   fix_next = fix_reg && (rd_data == PTYPE_IPV4[7:0]);
                6'd20:   fix_next = fix_reg && (rd_data == OP_REQUEST[15:8]);
                6'd21:   fix_next = fix_reg && (rd_data == OP_REQUEST[7:0]);
                [6'd32:6'd37]:
                    tmac_next = tmac_reg && (rd_data == mac_octet(server_mac, tmac_off[2:0]));
                [6'd38:6'd41]:
                    tip_next = tip_reg && (rd_data == ip_octet(server_ip, tip_off[1:0]));
                default: ;
            endcase
        end
    end

    // flag registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dmac_reg  <= 1'b1;
            bcast_reg <= 1'b1;
            fix_reg   <= 1'b1;
            tmac_reg  <= 1'b1;
            tip_reg   <= 1'b1;
        end
        else
        begin
            dmac_reg  <= dmac_next;
            bcast_reg <= bcast_next;
            fix_reg   <= fix_next;
            tmac_reg  <= tmac_next;
            tip_reg   <= tip_next;
        end
    end

    // passes when the destination is ours or broadcast, the fixed fields match and the target ip or mac matches
    assign pass = (dmac_reg || bcast_reg) && fix_reg && (tip_reg || tmac_reg);

endmodule

@@ hdl/arp_reply.sv @@
// reply byte builder and output register of the reply channel
// depends on arp_pkg
module arp_reply (
    input  logic                      clk,
    input  logic                      rst_n,
    input  arp_pkg::rd_tag_t          tag,
    input  logic [7:0]                rd_data,
    input  logic [arp_pkg::MAC_W-1:0] server_mac,
    input  logic [arp_pkg::IP_W-1:0]  server_ip,
    input  logic                      reply_stall,
    output logic                      reply_valid,
    output logic [7:0]                reply_byte,
    output logic                      reply_last
);
    import arp_pkg::*;

    logic             valid_reg;
    logic [7:0]       byte_reg, byte_next;
    logic             last_reg;
    logic [CNT_W-1:0] smac_off;
    logic [CNT_W-1:0] tmac_off;
    logic [CNT_W-1:0] sip_off;

    assign smac_off = tag.idx - 6'd6;
    assign tmac_off = tag.idx - 6'd22;
    assign sip_off  = tag.idx - 6'd28;

    // reply byte by position: copied from the store or generated
    always_comb
    begin
        case (tag.idx) inside
            [6'd0:6'd5]:   byte_next = rd_data;
            [6'd6:6'd11]:  byte_next = mac_octet(server_mac, smac_off[2:0]);
            [6'd12:6'd19]: byte_next = rd_data;
            6'd20:         byte_next = OP_REPLY[15:8];
            6'd21:         byte_next = OP_REPLY[7:0];
            [6'd22:6'd27]: byte_next = mac_octet(server_mac, tmac_off[2:0]);
            [6'd28:6'd31]: byte_next = ip_octet(server_ip, sip_off[1:0]);
            [6'd32:6'd41]: byte_next = rd_data;
            default:       byte_next = 8'd0;
        endcase
    end

    // output valid: set on load, cleared when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (tag.ld)
        begin
            valid_reg <= 1'b1;
        end
        else if (valid_reg && !reply_stall)
        begin
            valid_reg <= 1'b0;
        end
    end

    // output payload, loaded only into a free slot
    always_ff @(posedge clk)
    begin
        if (tag.ld)
        begin
            byte_reg <= byte_next;
            last_reg <= (tag.idx == LAST_IDX);
        end
    end

    assign reply_valid = valid_reg;
    assign reply_byte  = byte_reg;
    assign reply_last  = last_reg;

endmodule

@@ hdl/ethernet_arp_request_responder.sv @@
// top level of the arp request responder: header store, sequencer, config
// depends on arp_pkg, arp_ram, arp_check, arp_reply
//
// usage
//   input channel (in_valid / in_stall, in_byte, in_last): one frame byte per
//   beat, in_last on the final byte. while a frame is received the block takes
//   one beat per cycle and keeps the first 42 bytes in a 42 x 8 ram.
//   after the last beat of a frame of 42 or more bytes in_stall rises: the
//   stored header is read back one entry per cycle and checked, then the
//   settle and decide states give the verdict. a failing frame is dropped and
//   in_stall falls once the verdict is given; a shorter frame is dropped
//   at once and never stalls the input.
//   reply channel (reply_valid / reply_stall, reply_byte, reply_last): a
//   passing request gives 42 beats, reply_last on the final one. each beat
//   needs one ram read, then one output register load; a new read is issued
//   only once the previous one is loaded, so a single ram read is in flight. a
//   stalled receiver simply holds the output register and pauses the reads.
//   input reopens once the last reply read is issued.
//   config port (cfg_wr_en, cfg_index, cfg_data): server_mac at index 0,
//   server_ip at index 1, written while the block is idle.
//   reset: sequencer to receive, byte count to zero, registers to defaults;
//   ram contents are not cleared, entries are always written before read.
module ethernet_arp_request_responder (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [7:0]                    in_byte,
    input  logic                          in_last,
    output logic                          reply_valid,
    input  logic                          reply_stall,
    output logic [7:0]                    reply_byte,
    output logic                          reply_last,
    input  logic                          cfg_wr_en,
    input  logic [arp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arp_pkg::CFG_W-1:0]     cfg_data
);
    import arp_pkg::*;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] idx_reg, idx_next;
    rd_tag_t          rd_tag_reg, rd_tag_next;
    logic [MAC_W-1:0] mac_reg;
    logic [IP_W-1:0]  ip_reg;

    logic             in_accept;
    logic             ram_we;
    logic [CNT_W-1:0] rd_addr;
    logic [7:0]       rd_data;
    logic             issue_chk;
    logic             issue_ld;
    logic             out_free;
    logic             chk_clear;
    logic             pass;

    assign in_accept = in_valid && !in_stall;
    // output slot is free next cycle and no read is in flight
    assign out_free  = !rd_tag_reg.ld && (!reply_valid || !reply_stall);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_RECV:
            begin
                if (in_accept && in_last && (cnt_reg == HDR_BYTES || cnt_reg == LAST_IDX))
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (idx_reg == LAST_IDX)
                begin
                    state_next = ST_SETTLE;
                end
            end
            ST_SETTLE: state_next = ST_DECIDE;
            ST_DECIDE: state_next = pass ? ST_EMIT : ST_RECV;
            ST_EMIT:
            begin
                if (out_free && idx_reg == LAST_IDX)
                begin
                    state_next = ST_RECV;
                end
            end
            default: state_next = ST_RECV;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_stall  = 1'b1;
        issue_chk = 1'b0;
        issue_ld  = 1'b0;
        chk_clear = 1'b0;
        rd_addr   = idx_reg;
        case (state_reg)
            ST_RECV:
            begin
                in_stall  = 1'b0;
                chk_clear = 1'b1;
            end
            ST_SCAN:   issue_chk = 1'b1;
            ST_SETTLE: ;
            ST_DECIDE: ;
            ST_EMIT:
            begin
                issue_ld = out_free;
                rd_addr  = src_addr(idx_reg);
            end
            default: ;
        endcase
    end

    assign ram_we = in_accept && (cnt_reg != HDR_BYTES);

    // byte count and read index
    always_comb
    begin
        cnt_next = cnt_reg;
        if (in_accept)
        begin
            if (in_last)
            begin
                cnt_next = '0;
            end
            else if (cnt_reg != HDR_BYTES)
            begin
                cnt_next = cnt_reg + 6'd1;
            end
        end

        idx_next = idx_reg;
        if (issue_chk || issue_ld)
        begin
            idx_next = (idx_reg == LAST_IDX) ? '0 : idx_reg + 6'd1;
        end

        rd_tag_next.chk = issue_chk;
        rd_tag_next.ld  = issue_ld;
        rd_tag_next.idx = idx_reg;
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_RECV;
            cnt_reg    <= '0;
            idx_reg    <= '0;
            rd_tag_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            idx_reg    <= idx_next;
            rd_tag_reg <= rd_tag_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mac_reg <= MAC_RESET;
            ip_reg  <= IP_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SERVER_MAC: mac_reg <= cfg_data;
                CFG_SERVER_IP:  ip_reg  <= cfg_data[IP_W-1:0];
                default: ;
            endcase
        end
    end

    // header store
    arp_ram #(
        .WIDTH (8),
        .DEPTH (HDR_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (cnt_reg),
        .wdata (in_byte),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // request checks
    arp_check u_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (chk_clear),
        .tag        (rd_tag_reg),
        .rd_data    (rd_data),
        .server_mac (mac_reg),
        .server_ip  (ip_reg),
        .pass       (pass)
    );

    // reply builder and output register
    arp_reply u_reply (
        .clk         (clk),
        .rst_n       (rst_n),
        .tag         (rd_tag_reg),
        .rd_data     (rd_data),
        .server_mac  (mac_reg),
        .server_ip   (ip_reg),
        .reply_stall (reply_stall),
        .reply_valid (reply_valid),
        .reply_byte  (reply_byte),
        .reply_last  (reply_last)
    );

endmodule

@@ hdl/arp_checker.sv @@
// port-level assertions for the arp request responder, attached by bind
// no dependencies
module arp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       in_last,
    input logic       reply_valid,
    input logic       reply_stall,
    input logic [7:0] reply_byte,
    input logic       reply_last
);

    // stalled input beat holds
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(in_last))
        else $error("input beat changed while stalled");

    // stalled reply beat holds
    a_reply_hold: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && reply_stall |=> reply_valid && $stable(reply_byte)
            && $stable(reply_last))
        else $error("reply beat changed while stalled");

    // one store read per reply beat: no beats on back-to-back cycles
    a_reply_gap: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_stall |=> !reply_valid)
        else $error("reply beats closer than the store read allows");

    // input stays closed while a reply is still mid-burst
    a_in_closed: assert property (@(posedge clk) disable iff (!rst_n)
        reply_valid && !reply_stall && !reply_last |-> in_stall)
        else $error("input open during reply burst");

    // a reply burst never starts while frame bytes are being taken
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(reply_valid) && !reply_last |-> $past(in_stall))
        else $error("reply started while receiving");

endmodule

bind ethernet_arp_request_responder arp_checker u_arp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .in_last     (in_last),
    .reply_valid (reply_valid),
    .reply_stall (reply_stall),
    .reply_byte  (reply_byte),
    .reply_last  (reply_last)
);

@@ sim/tb_ethernet_arp_request_responder.sv @@
`timescale 1ns / 1ps
// testbench for ethernet_arp_request_responder: a directed frame table, then random frames
// under several server address settings, every reply beat checked against a local predictor
// depends on arp_pkg and the ethernet_arp_request_responder rtl
module tb_ethernet_arp_request_responder;
    import arp_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 100;
    localparam int RANDOM_BYTES  = 110;
    localparam int PHASE_BYTES   = 36;
    localparam int NUM_DIRECTED  = 7;

    // protocol values as the spec states them
    localparam logic [15:0] ARP_ETHERTYPE = 16'h0806;
    localparam logic [15:0] IPV4_PTYPE    = 16'h0800;
    localparam logic [15:0] ARP_REQUEST   = 16'h0001;
    localparam logic [15:0] ARP_REPLY     = 16'h0002;

    // how a frame is put together
    typedef enum logic [2:0] {
        DST_SERVER,
        DST_BCAST,
        DST_OTHER,
        DST_NEAR_BCAST
    } dst_e;

    typedef enum logic [1:0] {
        TGT_IP,
        TGT_MAC,
        TGT_BOTH,
        TGT_NONE
    } tgt_e;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_ODD_HW,
        FLAW_ETYPE,
        FLAW_PTYPE,
        FLAW_OPER,
        FLAW_NOISE
    } flaw_e;

    typedef enum logic [1:0] {
        FILL_RAND,
        FILL_ZERO,
        FILL_ONES
    } fill_e;

    typedef struct packed {
        dst_e       dst;
        tgt_e       tgt;
        flaw_e      flaw;
        fill_e      fill;
        logic [6:0] len;
        logic       drop;
    } frame_spec_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } reply_beat_t;

    // dut ports
    logic                 clk;
    logic                 rst_n       = 1'b0;
    logic                 in_valid    = 1'b0;
    logic                 in_stall;
    logic [7:0]           in_byte     = '0;
    logic                 in_last     = 1'b0;
    logic                 reply_valid;
    logic                 reply_stall = 1'b0;
    logic [7:0]           reply_byte;
    logic                 reply_last;
    logic                 cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index   = '0;
    logic [CFG_W-1:0]     cfg_data    = '0;

    // predictor state and server addresses as the block should hold them
    logic [MAC_W-1:0] cfg_mac = 48'h0001_0001_0001;
    logic [IP_W-1:0]  cfg_ip  = 32'h0a00_0002;
    logic [7:0]       hdr_seen [HDR_DEPTH];
    int               hdr_fill = 0;

    reply_beat_t reply_q [$];
    logic [7:0]  frame_buf [$];
    int          err_count   = 0;
    int          cycle_count = 0;
    int          reply_beats = 0;

    // directed frames; drop marks frames that must give no reply at all
    frame_spec_t directed_tbl [NUM_DIRECTED] = '{
        '{DST_BCAST,      TGT_IP,   FLAW_NONE,   FILL_RAND, 7'd42, 1'b0},
        '{DST_SERVER,     TGT_MAC,  FLAW_ODD_HW, FILL_ONES, 7'd43, 1'b0},
        '{DST_BCAST,      TGT_IP,   FLAW_NONE,   FILL_RAND, 7'd1,  1'b1},
        '{DST_BCAST,      TGT_IP,   FLAW_NONE,   FILL_RAND, 7'd41, 1'b1},
        '{DST_NEAR_BCAST, TGT_IP,   FLAW_NONE,   FILL_RAND, 7'd42, 1'b1},
        '{DST_BCAST,      TGT_NONE, FLAW_NONE,   FILL_RAND, 7'd42, 1'b1},
        '{DST_SERVER,     TGT_IP,   FLAW_ETYPE,  FILL_RAND, 7'd42, 1'b1}
    };

    ethernet_arp_request_responder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .in_last     (in_last),
        .reply_valid (reply_valid),
        .reply_stall (reply_stall),
        .reply_byte  (reply_byte),
        .reply_last  (reply_last),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic note_error(input string msg);
        $display("error at cycle %0d: %s", cycle_count, msg);
        err_count++;
    endtask

    // takes one accepted frame beat, queues the 42 reply beats when a request qualifies
    function automatic void arp_absorb_beat(input logic [7:0] b, input logic l, input bit keep);
        logic [7:0]  r [HDR_DEPTH];
        logic [47:0] dst_mac;
        logic [47:0] tgt_mac;
        logic [31:0] tgt_ip;
        logic        full;
        logic        ok;
        if (hdr_fill < HDR_DEPTH)
        begin
            hdr_seen[hdr_fill] = b;
            hdr_fill++;
        end
        if (!l)
            return;
        full     = (hdr_fill >= HDR_DEPTH);
        hdr_fill = 0;
        if (!full)
            return;
        dst_mac = '0;
        tgt_mac = '0;
        tgt_ip  = '0;
        for (int i = 0; i < 6; i++)
        begin
            dst_mac = {dst_mac[39:0], hdr_seen[i]};
            tgt_mac = {tgt_mac[39:0], hdr_seen[32 + i]};
        end
        for (int i = 0; i < 4; i++)
            tgt_ip = {tgt_ip[23:0], hdr_seen[38 + i]};
        ok = (dst_mac == cfg_mac || dst_mac == '1)
            && {hdr_seen[12], hdr_seen[13]} == ARP_ETHERTYPE
            && {hdr_seen[16], hdr_seen[17]} == IPV4_PTYPE
            && {hdr_seen[20], hdr_seen[21]} == ARP_REQUEST
            && (tgt_ip == cfg_ip || tgt_mac == cfg_mac);
        if (!ok || !keep)
            return;
        // reply: requester becomes target, server becomes sender
        for (int i = 0; i < 6; i++)
        begin
            r[i]      = hdr_seen[6 + i];
            r[6 + i]  = cfg_mac[8*(5-i) +: 8];
            r[22 + i] = cfg_mac[8*(5-i) +: 8];
            r[32 + i] = hdr_seen[22 + i];
        end
        for (int i = 12; i < 20; i++)
            r[i] = hdr_seen[i];
        r[20] = ARP_REPLY[15:8];
        r[21] = ARP_REPLY[7:0];
        for (int i = 0; i < 4; i++)
        begin
            r[28 + i] = cfg_ip[8*(3-i) +: 8];
            r[38 + i] = hdr_seen[28 + i];
        end
        for (int i = 0; i < HDR_DEPTH; i++)
            reply_q.push_back(reply_beat_t'{data: r[i], last: (i == HDR_DEPTH - 1)});
    endfunction

    function automatic logic [7:0] fill_octet(input fill_e f);
        case (f)
            FILL_ZERO: return 8'h00;
            FILL_ONES: return 8'hff;
            default:   return 8'($urandom);
        endcase
    endfunction

    // free address field of up to 48 bits
    function automatic logic [47:0] fill_word(input fill_e f);
        case (f)
            FILL_ZERO: return '0;
            FILL_ONES: return '1;
            default:   return {16'($urandom), $urandom};
        endcase
    endfunction

    // lays out one frame in frame_buf from a spec and the current server addresses
    function automatic void build_frame(input frame_spec_t s);
        logic [7:0]  h [HDR_DEPTH];
        logic [47:0] dst_mac;
        logic [47:0] eth_src;
        logic [47:0] sha;
        logic [47:0] tha;
        logic [31:0] spa;
        logic [31:0] tpa;
        logic [15:0] htype;
        logic [7:0]  hlen;
        logic [7:0]  plen;
        logic [7:0]  flip;
        int          k;
        eth_src = fill_word(s.fill);
        sha     = fill_word(s.fill);
        spa     = 32'(fill_word(s.fill));
        tha     = fill_word(s.fill);
        tpa     = 32'(fill_word(s.fill));
        flip    = 8'($urandom_range(1, 255));

        // destination: ours, broadcast, one octet off broadcast, or anything that is neither ours nor broadcast
        case (s.dst)
            DST_SERVER: dst_mac = cfg_mac;
            DST_BCAST:  dst_mac = '1;
            DST_NEAR_BCAST:
            begin
                dst_mac = '1;
                k = $urandom_range(0, 5);
                dst_mac[8*k +: 8] = dst_mac[8*k +: 8] ^ flip;
            end
            default:    dst_mac = fill_word(s.fill);
        endcase
        if (s.dst == DST_OTHER || s.dst == DST_NEAR_BCAST)
            while (dst_mac == cfg_mac || dst_mac == '1)
                dst_mac = dst_mac + 48'd1;

        // target match by ip, by mac, both or neither
        if (s.tgt == TGT_IP || s.tgt == TGT_BOTH)
            tpa = cfg_ip;
        else
            while (tpa == cfg_ip)
                tpa = tpa + 32'd1;
        if (s.tgt == TGT_MAC || s.tgt == TGT_BOTH)
            tha = cfg_mac;
        else
            while (tha == cfg_mac)
                tha = tha + 48'd1;

        // hardware type and lengths are copied, so odd values still get a reply
        if (s.flaw == FLAW_ODD_HW)
        begin
            htype = 16'(fill_word(s.fill));
            hlen  = fill_octet(s.fill);
            plen  = fill_octet(s.fill);
        end
        else
        begin
            htype = 16'h0001;
            hlen  = 8'd6;
            plen  = 8'd4;
        end

        for (int i = 0; i < 6; i++)
        begin
            h[i]      = dst_mac[8*(5-i) +: 8];
            h[6 + i]  = eth_src[8*(5-i) +: 8];
            h[22 + i] = sha[8*(5-i) +: 8];
            h[32 + i] = tha[8*(5-i) +: 8];
        end
        h[12] = ARP_ETHERTYPE[15:8];
        h[13] = ARP_ETHERTYPE[7:0];
        h[14] = htype[15:8];
        h[15] = htype[7:0];
        h[16] = IPV4_PTYPE[15:8];
        h[17] = IPV4_PTYPE[7:0];
        h[18] = hlen;
        h[19] = plen;
        h[20] = ARP_REQUEST[15:8];
        h[21] = ARP_REQUEST[7:0];
        for (int i = 0; i < 4; i++)
        begin
            h[28 + i] = spa[8*(3-i) +: 8];
            h[38 + i] = tpa[8*(3-i) +: 8];
        end

        // single octet corruption of one checked field, or pure noise
        case (s.flaw)
            FLAW_ETYPE:
            begin
                k = $urandom_range(12, 13);
                h[k] = h[k] ^ flip;
            end
            FLAW_PTYPE:
            begin
                k = $urandom_range(16, 17);
                h[k] = h[k] ^ flip;
            end
            FLAW_OPER:
            begin
                k = $urandom_range(20, 21);
                h[k] = h[k] ^ flip;
            end
            FLAW_NOISE:
                for (int i = 0; i < HDR_DEPTH; i++)
                    h[i] = 8'($urandom);
            default: ;
        endcase

        frame_buf.delete();
        for (int i = 0; i < int'(s.len); i++)
            frame_buf.push_back(i < HDR_DEPTH ? h[i] : fill_octet(s.fill));
    endfunction

    function automatic frame_spec_t random_spec();
        frame_spec_t s;
        int          r;
        r      = $urandom_range(0, 99);
        s.dst  = $urandom_range(0, 1) ? DST_BCAST : DST_SERVER;
        s.tgt  = tgt_e'($urandom_range(0, 2));
        s.flaw = ($urandom_range(0, 4) == 0) ? FLAW_ODD_HW : FLAW_NONE;
        s.fill = ($urandom_range(0, 9) == 0) ? fill_e'($urandom_range(1, 2)) : FILL_RAND;
        s.len  = ($urandom_range(0, 7) == 0) ? 7'($urandom_range(43, 64))
                                               : 7'(42 + $urandom_range(0, 2));
        s.drop = 1'b0;
        // most frames are good requests; the rest broken requests and noise
        if (r >= 85)
        begin
            s.flaw = FLAW_NOISE;
            s.len  = 7'($urandom_range(1, 64));
        end
        else if (r >= 70)
        begin
            case ($urandom_range(0, 6))
                0:       s.dst  = DST_OTHER;
                1:       s.dst  = DST_NEAR_BCAST;
                2:       s.tgt  = TGT_NONE;
                3:       s.flaw = FLAW_ETYPE;
                4:       s.flaw = FLAW_PTYPE;
                5:       s.flaw = FLAW_OPER;
                default: s.len  = 7'($urandom_range(1, 41));
            endcase
        end
        return s;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one frame beat, held until accepted
    task automatic send_beat(input logic [7:0] b, input logic l, input int gap,
                             input bit no_reply);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_byte  <= b;
        in_last  <= l;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        arp_absorb_beat(b, l, !no_reply);
    endtask

    task automatic send_frame(input frame_spec_t s, output int sent);
        bit burst;
        build_frame(s);
        burst = ($urandom_range(0, 2) == 0);
        foreach (frame_buf[i])
            send_beat(frame_buf[i], i == frame_buf.size() - 1, burst ? 0 : pick_gap(), s.drop);
        sent = frame_buf.size();
    endtask

    // sender holds off until every reply beat is in and a dropped frame has been scanned
    task automatic drain_replies();
        in_valid <= 1'b0;
        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_server_regs(input logic [MAC_W-1:0] mac, input logic [IP_W-1:0] ip);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SERVER_MAC;
        cfg_data  <= mac;
        @(posedge clk);
        // bits above the ip width must be ignored
        cfg_index <= CFG_SERVER_IP;
        cfg_data  <= {16'($urandom), ip};
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        cfg_mac = mac;
        cfg_ip  = ip;
    endtask

    // reply side stall: short bursts mostly, now and then long, with open stretches
    initial
    begin : reply_stall_gen
        int n;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 120) : $urandom_range(1, 8);
            reply_stall <= 1'b0;
            repeat (n) @(posedge clk);
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 50) : $urandom_range(1, 3);
            reply_stall <= 1'b1;
            repeat (n) @(posedge clk);
        end
    end

    // reply beat checker
    always @(posedge clk)
    begin : reply_check
        reply_beat_t want;
        if (rst_n && reply_valid === 1'b1 && reply_stall === 1'b0)
        begin
            if (reply_q.size() == 0)
                note_error($sformatf("reply beat %02h with no reply pending", reply_byte));
            else
            begin
                want = reply_q.pop_front();
                if (reply_byte !== want.data)
                    note_error($sformatf("reply byte %0d: got %02h want %02h",
                                         reply_beats % HDR_DEPTH, reply_byte, want.data));
                if (reply_last !== want.last)
                    note_error($sformatf("reply byte %0d: last got %b want %b",
                                         reply_beats % HDR_DEPTH, reply_last, want.last));
            end
            reply_beats++;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            note_error("cycle limit reached");
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    initial
    begin : stimulus
        int sent;
        int phase_bytes;
        int rnd_bytes;
        int p;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed frames under the reset addresses
        foreach (directed_tbl[i])
            send_frame(directed_tbl[i], sent);

        // random frames, address extremes first, then random addresses
        rnd_bytes = 0;
        p         = 0;
        while (rnd_bytes < RANDOM_BYTES)
        begin
            drain_replies();
            case (p)
                0:       write_server_regs('0, '0);
                1:       write_server_regs('1, '1);
                default: write_server_regs({16'($urandom), $urandom}, $urandom);
            endcase
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
            begin
                send_frame(random_spec(), sent);
                phase_bytes += sent;
            end
            rnd_bytes += phase_bytes;
            p++;
        end

        drain_replies();
        if (err_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ sim.f @@
hdl/arp_pkg.sv
hdl/arp_ram.sv
hdl/arp_check.sv
hdl/arp_reply.sv
hdl/ethernet_arp_request_responder.sv
hdl/arp_checker.sv
sim/tb_ethernet_arp_request_responder.sv
